[hdl/alli_pkg.sv]
// package for the array linked list inserter: stream layout, codes and the
// control program of the sequencer
// depends on nothing
package alli_pkg;

  localparam int IN_W  = 80;
  localparam int OUT_W = 24;
  localparam int PC_W  = 5;

  localparam logic [1:0] ACT_FRONT = 2'd0;
  localparam logic [1:0] ACT_POS   = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;
  localparam logic [1:0] ACT_KEY   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_KEY  = 2'd1;
  localparam logic [1:0] ST_BAD_POS = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_CUR_HEAD,
    OP_READ,
    OP_ADVANCE,
    OP_NEW_AFTER_CUR,
    OP_NEW_AFTER_PREV,
    OP_LINK_TGT,
    OP_WRITE_FRONT,
    OP_SET_FULL,
    OP_SET_NO_KEY,
    OP_SET_BAD_POS,
    OP_RESPOND
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_FULL,
    C_FRONT,
    C_ACT_POS,
    C_ACT_END,
    C_CUR_NULL,
    C_PREV_NULL,
    C_LINK_NULL,
    C_KEY_HIT,
    C_POS_DONE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic no_req;
    logic full;
    logic front;
    logic act_pos;
    logic act_end;
    logic cur_null;
    logic prev_null;
    logic link_null;
    logic key_hit;
    logic pos_done;
    logic out_free;
  } flags_t;

  // step addresses
  localparam logic [PC_W-1:0] S_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] S_D_FULL    = 5'd1;
  localparam logic [PC_W-1:0] S_D_FRONT   = 5'd2;
  localparam logic [PC_W-1:0] S_D_POS     = 5'd3;
  localparam logic [PC_W-1:0] S_D_END     = 5'd4;
  localparam logic [PC_W-1:0] S_K_HEAD    = 5'd5;
  localparam logic [PC_W-1:0] S_K_TEST    = 5'd6;
  localparam logic [PC_W-1:0] S_K_READ    = 5'd7;
  localparam logic [PC_W-1:0] S_K_CMP     = 5'd8;
  localparam logic [PC_W-1:0] S_K_ADV     = 5'd9;
  localparam logic [PC_W-1:0] S_K_FOUND   = 5'd10;
  localparam logic [PC_W-1:0] S_K_NEW     = 5'd11;
  localparam logic [PC_W-1:0] S_K_LINK    = 5'd12;
  localparam logic [PC_W-1:0] S_P_HEAD    = 5'd13;
  localparam logic [PC_W-1:0] S_P_TEST    = 5'd14;
  localparam logic [PC_W-1:0] S_P_READ    = 5'd15;
  localparam logic [PC_W-1:0] S_P_ADV     = 5'd16;
  localparam logic [PC_W-1:0] S_P_END     = 5'd17;
  localparam logic [PC_W-1:0] S_A_READ    = 5'd18;
  localparam logic [PC_W-1:0] S_A_NEW     = 5'd19;
  localparam logic [PC_W-1:0] S_A_LINK    = 5'd20;
  localparam logic [PC_W-1:0] S_E_HEAD    = 5'd21;
  localparam logic [PC_W-1:0] S_E_READ    = 5'd22;
  localparam logic [PC_W-1:0] S_E_TEST    = 5'd23;
  localparam logic [PC_W-1:0] S_E_ADV     = 5'd24;
  localparam logic [PC_W-1:0] S_FRONT     = 5'd25;
  localparam logic [PC_W-1:0] S_FULL      = 5'd26;
  localparam logic [PC_W-1:0] S_NO_KEY    = 5'd27;
  localparam logic [PC_W-1:0] S_BAD_POS   = 5'd28;
  localparam logic [PC_W-1:0] S_RESP      = 5'd29;
  localparam logic [PC_W-1:0] S_RESP_WAIT = 5'd30;

  function automatic ctl_word_t rom_word(logic [PC_W-1:0] a);
    ctl_word_t w;
    case (a)
      S_IDLE:      w = '{OP_LATCH,          C_NO_REQ,    S_IDLE};
      S_D_FULL:    w = '{OP_NOP,            C_FULL,      S_FULL};
      S_D_FRONT:   w = '{OP_NOP,            C_FRONT,     S_FRONT};
      S_D_POS:     w = '{OP_NOP,            C_ACT_POS,   S_P_HEAD};
      S_D_END:     w = '{OP_NOP,            C_ACT_END,   S_E_HEAD};
      S_K_HEAD:    w = '{OP_CUR_HEAD,       C_NEVER,     S_IDLE};
      S_K_TEST:    w = '{OP_NOP,            C_CUR_NULL,  S_NO_KEY};
      S_K_READ:    w = '{OP_READ,           C_NEVER,     S_IDLE};
      S_K_CMP:     w = '{OP_NOP,            C_KEY_HIT,   S_K_FOUND};
      S_K_ADV:     w = '{OP_ADVANCE,        C_ALWAYS,    S_K_TEST};
      S_K_FOUND:   w = '{OP_NOP,            C_PREV_NULL, S_FRONT};
      S_K_NEW:     w = '{OP_NEW_AFTER_PREV, C_NEVER,     S_IDLE};
      S_K_LINK:    w = '{OP_LINK_TGT,       C_ALWAYS,    S_RESP};
      S_P_HEAD:    w = '{OP_CUR_HEAD,       C_NEVER,     S_IDLE};
      S_P_TEST:    w = '{OP_NOP,            C_POS_DONE,  S_P_END};
      S_P_READ:    w = '{OP_READ,           C_NEVER,     S_IDLE};
      S_P_ADV:     w = '{OP_ADVANCE,        C_ALWAYS,    S_P_TEST};
      S_P_END:     w = '{OP_NOP,            C_CUR_NULL,  S_BAD_POS};
      S_A_READ:    w = '{OP_READ,           C_NEVER,     S_IDLE};
      S_A_NEW:     w = '{OP_NEW_AFTER_CUR,  C_NEVER,     S_IDLE};
      S_A_LINK:    w = '{OP_LINK_TGT,       C_ALWAYS,    S_RESP};
      S_E_HEAD:    w = '{OP_CUR_HEAD,       C_NEVER,     S_IDLE};
      S_E_READ:    w = '{OP_READ,           C_NEVER,     S_IDLE};
      S_E_TEST:    w = '{OP_NOP,            C_LINK_NULL, S_A_NEW};
      S_E_ADV:     w = '{OP_ADVANCE,        C_ALWAYS,    S_E_READ};
      S_FRONT:     w = '{OP_WRITE_FRONT,    C_ALWAYS,    S_RESP};
      S_FULL:      w = '{OP_SET_FULL,       C_ALWAYS,    S_RESP};
      S_NO_KEY:    w = '{OP_SET_NO_KEY,     C_ALWAYS,    S_RESP};
      S_BAD_POS:   w = '{OP_SET_BAD_POS,    C_ALWAYS,    S_RESP};
      S_RESP:      w = '{OP_RESPOND,        C_OUT_FREE,  S_IDLE};
      S_RESP_WAIT: w = '{OP_NOP,            C_ALWAYS,    S_RESP};
      default:     w = '{OP_NOP,            C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hdl/alli_seq.sv]
// step counter and control program of the inserter
// depends on alli_pkg
module alli_seq
  import alli_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  flags_t    flags,
  output ctl_word_t ctl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctl = rom_word(pc);

  always_comb begin
    case (ctl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_REQ:    take = flags.no_req;
      C_FULL:      take = flags.full;
      C_FRONT:     take = flags.front;
      C_ACT_POS:   take = flags.act_pos;
      C_ACT_END:   take = flags.act_end;
      C_CUR_NULL:  take = flags.cur_null;
      C_PREV_NULL: take = flags.prev_null;
      C_LINK_NULL: take = flags.link_null;
      C_KEY_HIT:   take = flags.key_hit;
      C_POS_DONE:  take = flags.pos_done;
      C_OUT_FREE:  take = flags.out_free;
      default:     take = 1'b0;
    endcase
  end

  assign pc_next = take ? ctl.target : pc + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[hdl/alli_dp.sv]
// datapath of the inserter: request registers, value and link stores,
// walk registers and the result register
// depends on alli_pkg
module alli_dp
  import alli_pkg::*;
#(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_word_t        ctl,
  output flags_t           flags,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = LW + 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);

  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [LW-1:0]          link_mem  [DEPTH];

  logic [1:0]             act;
  logic [VALUE_WIDTH-1:0] val;
  logic [8:0]             pos;
  logic [VALUE_WIDTH-1:0] key;
  logic [LW-1:0]          cur;
  logic [LW-1:0]          prev;
  logic [LW-1:0]          tgt;
  logic [CW-1:0]          cnt;
  logic [AW-1:0]          slot;
  logic [1:0]             status;
  logic [LW-1:0]          head;
  logic [LW-1:0]          free;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [LW-1:0]          rd_link;

  logic                   fire;
  logic                   out_busy;
  logic [VALUE_WIDTH+31:0] val_wide;
  logic [VALUE_WIDTH+31:0] key_wide;
  logic                   val_we;
  logic                   link_we;
  logic [LW-1:0]          link_addr;
  logic [LW-1:0]          link_wdata;
  logic [AW+7:0]          slot_wide;
  logic [LW+8:0]          len_wide;
  logic [7:0]             slot_out;

  assign s_tready = (ctl.op == OP_LATCH);
  assign fire     = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;

  assign val_wide = (VALUE_WIDTH + 32)'(signed'(s_tdata[33:2]));
  assign key_wide = (VALUE_WIDTH + 32)'(signed'(s_tdata[74:43]));

  // flags for the jump conditions
  always_comb begin
    flags.no_req    = !s_tvalid;
    flags.full      = (free >= NULL_LINK);
    flags.front     = (act == ACT_FRONT) || ((act != ACT_KEY) && (head == NULL_LINK)) ||
                      ((act == ACT_POS) && (pos == 9'd0));
    flags.act_pos   = (act == ACT_POS);
    flags.act_end   = (act == ACT_END);
    flags.cur_null  = (cur == NULL_LINK);
    flags.prev_null = (prev == NULL_LINK);
    flags.link_null = (rd_link == NULL_LINK);
    flags.key_hit   = (rd_val == key);
    flags.pos_done  = ((CW + 9)'(cnt) >= (CW + 9)'(pos)) || (cur == NULL_LINK);
    flags.out_free  = !out_busy;
  end

  // store write port selection
  always_comb begin
    val_we     = 1'b0;
    link_we    = 1'b0;
    link_addr  = free;
    link_wdata = head;
    case (ctl.op)
      OP_NEW_AFTER_CUR: begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_wdata = rd_link;
      end
      OP_NEW_AFTER_PREV: begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_wdata = cur;
      end
      OP_LINK_TGT: begin
        link_we    = 1'b1;
        link_addr  = tgt;
        link_wdata = free;
      end
      OP_WRITE_FRONT: begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_wdata = head;
      end
      default: begin
        val_we     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[free[AW-1:0]] <= val;
    end
    if (link_we) begin
      link_mem[link_addr[AW-1:0]] <= link_wdata;
    end
    if (ctl.op == OP_READ) begin
      rd_val  <= value_mem[cur[AW-1:0]];
      rd_link <= link_mem[cur[AW-1:0]];
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        if (fire) begin
          act    <= s_tdata[1:0];
          val    <= val_wide[VALUE_WIDTH-1:0];
          pos    <= s_tdata[42:34];
          key    <= key_wide[VALUE_WIDTH-1:0];
          status <= ST_OK;
        end
      end
      OP_CUR_HEAD: begin
        cur  <= head;
        prev <= NULL_LINK;
        cnt  <= CW'(1);
      end
      OP_ADVANCE: begin
        prev <= cur;
        cur  <= rd_link;
        cnt  <= cnt + 1'b1;
      end
      OP_NEW_AFTER_CUR: begin
        tgt  <= cur;
        slot <= free[AW-1:0];
      end
      OP_NEW_AFTER_PREV: begin
        tgt  <= prev;
        slot <= free[AW-1:0];
      end
      OP_WRITE_FRONT: begin
        slot <= free[AW-1:0];
      end
      OP_SET_FULL:    status <= ST_FULL;
      OP_SET_NO_KEY:  status <= ST_NO_KEY;
      OP_SET_BAD_POS: status <= ST_BAD_POS;
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // list head and bump pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= NULL_LINK;
      free <= '0;
    end else begin
      case (ctl.op)
        OP_WRITE_FRONT: begin
          head <= free;
          free <= free + 1'b1;
        end
        OP_LINK_TGT: begin
          free <= free + 1'b1;
        end
        default: begin
          free <= free;
        end
      endcase
    end
  end

  // result register
  assign slot_wide = (AW + 8)'(slot);
  assign len_wide  = (LW + 9)'(free);
  assign slot_out  = (status == ST_OK) ? slot_wide[7:0] : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.op == OP_RESPOND && !out_busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_RESPOND && !out_busy) begin
      m_tdata <= {(OUT_W - 19)'(0), len_wide[8:0], slot_out, status};
    end
  end

endmodule

[hdl/array_linked_list_inserter.sv]
// top level of the array linked list inserter
// depends on alli_pkg, alli_seq and alli_dp
//
// Inserts one value per request into a singly linked list held in a value
// store and a link store of DEPTH entries, slots handed out in order. After
// a request is taken the block is busy until its result is loaded into the
// output register; the next request is taken while that result waits.
// Position and end inserts walk the list node by node, each visit being
// one registered store read, the jump that tests it and the advance; key
// inserts add the key compare to each visit. No clearing pass follows
// reset.
module array_linked_list_inserter
  import alli_pkg::*;
#(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // action, value, position, search_key, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status, slot_used, list_length, zero pad
);

  ctl_word_t ctl;
  flags_t    flags;

  alli_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  alli_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .flags    (flags),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[hdl/alli_chk.sv]
// port checker for the array linked list inserter, bound to the top level
// depends on alli_pkg and array_linked_list_inserter
module alli_chk
  import alli_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_OK) || (m_tdata[9:2] == 8'd0))
    else $error("slot reported for a rejected request");

endmodule

bind array_linked_list_inserter alli_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
